### design/iawi_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iawi_pkg
// Shared types and defaults for the indexed word array with insert.
// ----------------------------------------------------------------------------
package iawi_pkg;

    localparam int DEF_CAPACITY   = 64;
    localparam int DEF_DATA_WIDTH = 32;

    typedef enum logic [1:0] {
        MODE_GET    = 2'd0,
        MODE_SET    = 2'd1,
        MODE_APPEND = 2'd2,
        MODE_INSERT = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        STS_DONE  = 2'd0,
        STS_INDEX = 2'd1,
        STS_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } t_state;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic we;
        logic shift;
    } t_cell_ctl;

endpackage
`default_nettype wire

### design/iawi_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iawi_cell
// One entry of the array: holds a word, takes its left neighbor on a shift,
// takes the write word when addressed, and drives its word onto the read tree.
// ----------------------------------------------------------------------------
module iawi_cell #(
    parameter int POS = 0,
    parameter int W   = 32,
    parameter int IW  = 7
) (
    input  wire logic                i_clk,
    input  wire iawi_pkg::t_cell_ctl i_ctl,
    input  wire logic [IW-1:0]       i_pos,
    input  wire logic [IW-1:0]       i_rd_pos,
    input  wire logic [W-1:0]        i_data,
    input  wire logic [W-1:0]        i_left,
    output logic      [W-1:0]        o_data,
    output logic      [W-1:0]        o_read
);
    import iawi_pkg::*;

    localparam logic [IW-1:0] POS_L = IW'(POS);

    logic [W-1:0] r_data;
    logic [W-1:0] n_data;

    always_comb begin
        n_data = r_data;
        priority if (i_ctl.shift && (POS_L > i_pos)) begin
            n_data = i_left;
        end else if (i_ctl.we && (POS_L == i_pos)) begin
            n_data = i_data;
        end else begin
            n_data = r_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_read = (i_rd_pos == POS_L) ? r_data : '0;

endmodule
`default_nettype wire

### design/iawi_or_tree.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iawi_or_tree
// Registered OR tree that gathers the one selected cell word, one register
// level per tree level.
// ----------------------------------------------------------------------------
module iawi_or_tree #(
    parameter int N = 64,
    parameter int W = 32
) (
    input  wire logic         i_clk,
    input  wire logic [W-1:0] i_leaf [N],
    output logic      [W-1:0] o_root
);
    import iawi_pkg::*;

    localparam int LEVELS = $clog2(N);
    localparam int P      = 1 << LEVELS;

    logic [W-1:0] w_leaf [P];
    logic [W-1:0] r_node [P-1];

    genvar j;
    genvar i;

    generate
        for (j = 0; j < P; j++) begin : g_leaf
            if (j < N) begin : g_real
                assign w_leaf[j] = i_leaf[j];
            end else begin : g_pad
                assign w_leaf[j] = '0;
            end
        end

        for (i = 0; i < P - 1; i++) begin : g_node
            if (2 * i + 1 >= P - 1) begin : g_bottom
                always_ff @(posedge i_clk) begin
                    r_node[i] <= w_leaf[2*i+1-(P-1)] | w_leaf[2*i+2-(P-1)];
                end
            end else begin : g_inner
                always_ff @(posedge i_clk) begin
                    r_node[i] <= r_node[2*i+1] | r_node[2*i+2];
                end
            end
        end
    endgenerate

    assign o_root = r_node[0];

endmodule
`default_nettype wire

### design/indexed_array_with_insert.sv
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_array_with_insert
// Ordered array of up to CAPACITY words with get, set, append and insert.
// ----------------------------------------------------------------------------
// Each entry lives in a cell of a chain; an insert moves every later entry up
// one cell together. Set, append, insert and any request that ends in an error
// load their result when accepted: it sits in the output register on the next
// cycle and a new word is accepted at once. A get that succeeds reads through a
// registered OR tree of $clog2(CAPACITY) levels and blocks the input until its
// result is loaded into the output register. The input is also held off while
// a finished result waits in the output register and the output is stalled.
// ----------------------------------------------------------------------------
module indexed_array_with_insert #(
    parameter int CAPACITY   = iawi_pkg::DEF_CAPACITY,
    parameter int DATA_WIDTH = iawi_pkg::DEF_DATA_WIDTH,
    parameter int IDX_W      = $clog2(CAPACITY + 1)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [1:0]            i_mode,
    input  wire logic [IDX_W-1:0]      i_index,
    input  wire logic [DATA_WIDTH-1:0] i_write_data,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic      [1:0]            o_status,
    output logic      [DATA_WIDTH-1:0] o_read_data,
    output logic      [IDX_W-1:0]      o_used_count
);
    import iawi_pkg::*;

    localparam int              TREE_DEPTH = $clog2(CAPACITY);
    localparam int              CNT_W      = $clog2(TREE_DEPTH + 1);
    localparam logic [IDX_W-1:0] CAP_L     = IDX_W'(CAPACITY);

    t_state               r_state;
    t_state               n_state;
    logic [CNT_W-1:0]     r_cnt;
    logic [IDX_W-1:0]     r_rd_idx;
    logic [IDX_W-1:0]     r_count;
    logic [IDX_W-1:0]     n_count;
    logic                 r_out_valid;
    t_status              r_status;
    logic [DATA_WIDTH-1:0] r_read_data;
    logic [IDX_W-1:0]     r_used_count;

    t_mode                mode;
    t_status              op_status;
    logic                 op_write;
    logic                 op_shift;
    logic                 op_inc;
    logic                 op_read;
    logic [IDX_W-1:0]     op_pos;
    logic                 idx_lt;
    logic                 idx_le;
    logic                 full;

    logic                 out_free;
    logic                 stall_in;
    logic                 in_acc;
    logic                 load_out;
    t_cell_ctl            cell_ctl;

    logic [DATA_WIDTH-1:0] w_data [CAPACITY];
    logic [DATA_WIDTH-1:0] w_read [CAPACITY];
    logic [DATA_WIDTH-1:0] tree_root;

    // request decode
    always_comb begin
        mode      = t_mode'(i_mode);
        idx_lt    = i_index < r_count;
        idx_le    = i_index <= r_count;
        full      = r_count == CAP_L;
        op_status = STS_DONE;
        op_write  = 1'b0;
        op_shift  = 1'b0;
        op_inc    = 1'b0;
        op_read   = 1'b0;
        op_pos    = i_index;
        unique case (mode)
            MODE_GET: begin
                op_status = idx_lt ? STS_DONE : STS_INDEX;
                op_read   = idx_lt;
            end
            MODE_SET: begin
                op_status = idx_lt ? STS_DONE : STS_INDEX;
                op_write  = idx_lt;
            end
            MODE_APPEND: begin
                op_status = full ? STS_FULL : STS_DONE;
                op_write  = !full;
                op_inc    = !full;
                op_pos    = r_count;
            end
            MODE_INSERT: begin
                if (!idx_le) begin
                    op_status = STS_INDEX;
                end else if (full) begin
                    op_status = STS_FULL;
                end else begin
                    op_write = 1'b1;
                    op_shift = 1'b1;
                    op_inc   = 1'b1;
                end
            end
            default: begin
                op_status = STS_DONE;
            end
        endcase
    end

    assign out_free = !r_out_valid || !i_out_stall;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && op_read) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                if ((r_cnt == '0) && out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        stall_in = 1'b1;
        load_out = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                stall_in = !out_free;
                load_out = i_in_valid && out_free && !op_read;
            end
            S_READ: begin
                stall_in = 1'b1;
                load_out = (r_cnt == '0) && out_free;
            end
            default: begin
                stall_in = 1'b1;
                load_out = 1'b0;
            end
        endcase
    end

    assign in_acc         = i_in_valid && !stall_in;
    assign cell_ctl.we    = in_acc && op_write;
    assign cell_ctl.shift = in_acc && op_shift;
    assign n_count        = (in_acc && op_inc) ? r_count + IDX_W'(1) : r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_rd_idx    <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (in_acc && op_read) begin
                r_cnt    <= CNT_W'(TREE_DEPTH);
                r_rd_idx <= i_index;
            end else if ((r_state == S_READ) && (r_cnt != '0)) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            if (r_state == S_READ) begin
                r_status     <= STS_DONE;
                r_read_data  <= tree_root;
                r_used_count <= r_count;
            end else begin
                r_status     <= op_status;
                r_read_data  <= '0;
                r_used_count <= n_count;
            end
        end
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic [DATA_WIDTH-1:0] w_left;
            if (g == 0) begin : g_first
                assign w_left = '0;
            end else begin : g_rest
                assign w_left = w_data[g-1];
            end
            iawi_cell #(
                .POS (g),
                .W   (DATA_WIDTH),
                .IW  (IDX_W)
            ) u_cell (
                .i_clk    (i_clk),
                .i_ctl    (cell_ctl),
                .i_pos    (op_pos),
                .i_rd_pos (r_rd_idx),
                .i_data   (i_write_data),
                .i_left   (w_left),
                .o_data   (w_data[g]),
                .o_read   (w_read[g])
            );
        end
    endgenerate

    iawi_or_tree #(
        .N (CAPACITY),
        .W (DATA_WIDTH)
    ) u_tree (
        .i_clk  (i_clk),
        .i_leaf (w_read),
        .o_root (tree_root)
    );

    assign o_in_stall   = stall_in;
    assign o_out_valid  = r_out_valid;
    assign o_status     = r_status;
    assign o_read_data  = r_read_data;
    assign o_used_count = r_used_count;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_L)
        else $error("fill count above capacity");

    a_read_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (o_in_stall && !cell_ctl.we && !cell_ctl.shift))
        else $error("array changed during a tree read");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (n_count != r_count) |-> (in_acc && (n_count == r_count + IDX_W'(1))))
        else $error("fill count moved by other than one accepted word");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> out_free)
        else $error("result loaded over a pending word");

endmodule
`default_nettype wire

### verif/indexed_array_with_insert_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// indexed_array_with_insert_test
// Self-checking bench for the indexed word array with insert.
// ----------------------------------------------------------------------------
// A shadow copy of the array and its count predicts status, read word and
// count for every accepted request. Directed requests cover the empty array,
// index bounds, insert at the count and the full array. Random requests then
// build the array up to capacity and keep working on the full array. Both
// channels idle at random, and one phase holds the output long enough to
// back up the input.
// ----------------------------------------------------------------------------
module indexed_array_with_insert_test;
    import iawi_pkg::*;

    localparam int CAP            = DEF_CAPACITY;
    localparam int DW             = DEF_DATA_WIDTH;
    localparam int IW             = $clog2(CAP + 1);
    localparam int TIMEOUT_CYCLES = 200000;
    localparam int LONG_HOLD      = 300;
    localparam int TAIL_CYCLES    = 20;

    localparam int STALL_NONE    = 0;
    localparam int STALL_LIGHT   = 1;
    localparam int STALL_HEAVY   = 2;
    localparam int STALL_PATTERN = 3;

    typedef struct {
        t_status       status;
        logic [DW-1:0] read_data;
        logic [IW-1:0] used_count;
    } t_result;

    logic          i_clk        = 1'b0;
    logic          i_rst_n      = 1'b0;
    logic          i_in_valid   = 1'b0;
    logic [1:0]    i_mode       = MODE_GET;
    logic [IW-1:0] i_index      = '0;
    logic [DW-1:0] i_write_data = '0;
    logic          i_out_stall  = 1'b0;
    logic          o_in_stall;
    logic          o_out_valid;
    logic [1:0]    o_status;
    logic [DW-1:0] o_read_data;
    logic [IW-1:0] o_used_count;

    logic [DW-1:0] shadow_words [CAP];
    int            shadow_count = 0;
    t_result       pending_results [$];
    int            failures     = 0;
    int            cycle_count  = 0;
    int            stall_style  = STALL_NONE;
    int            hold_request = 0;
    int            hold_left    = 0;
    int            burst_left   = 0;

    indexed_array_with_insert #(
        .CAPACITY   (CAP),
        .DATA_WIDTH (DW)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_mode       (i_mode),
        .i_index      (i_index),
        .i_write_data (i_write_data),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_read_data  (o_read_data),
        .o_used_count (o_used_count)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > TIMEOUT_CYCLES) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver stall pattern, with a long hold on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                case (stall_style)
                    STALL_LIGHT:   i_out_stall <= ($urandom_range(0, 4) == 0);
                    STALL_HEAVY:   i_out_stall <= ($urandom_range(0, 2) != 0);
                    STALL_PATTERN: i_out_stall <= ((cycle_count % 9) < 4);
                    default:       i_out_stall <= 1'b0;
                endcase
            end
        end
    end

    function automatic t_result predict_array_op(t_mode mode, logic [IW-1:0] idx,
                                                 logic [DW-1:0] data);
        t_result r;
        r.status    = STS_DONE;
        r.read_data = '0;
        case (mode)
            MODE_GET: begin
                if (idx >= shadow_count) r.status = STS_INDEX;
                else r.read_data = shadow_words[idx];
            end
            MODE_SET: begin
                if (idx >= shadow_count) r.status = STS_INDEX;
                else shadow_words[idx] = data;
            end
            MODE_APPEND: begin
                if (shadow_count >= CAP) begin
                    r.status = STS_FULL;
                end else begin
                    shadow_words[shadow_count] = data;
                    shadow_count++;
                end
            end
            default: begin
                if (idx > shadow_count) begin
                    r.status = STS_INDEX;
                end else if (shadow_count >= CAP) begin
                    r.status = STS_FULL;
                end else begin
                    for (int k = shadow_count; k > idx; k--)
                        shadow_words[k] = shadow_words[k-1];
                    shadow_words[idx] = data;
                    shadow_count++;
                end
            end
        endcase
        r.used_count = shadow_count[IW-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (pending_results.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected word: status %0d read %h count %0d",
                             o_status, o_read_data, o_used_count);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status || o_read_data !== want.read_data ||
                    o_used_count !== want.used_count) begin
                    failures++;
                    if (failures <= 10)
                        $display("word mismatch: status %0d/%0d read %h/%h count %0d/%0d",
                                 want.status, o_status, want.read_data, o_read_data,
                                 want.used_count, o_used_count);
                end
            end
        end
    end

    // valid stays high after acceptance; a gap lowers it
    task automatic send_word(t_mode mode, logic [IW-1:0] idx, logic [DW-1:0] data);
        i_in_valid   <= 1'b1;
        i_mode       <= mode;
        i_index      <= idx;
        i_write_data <= data;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_results.push_back(predict_array_op(mode, idx, data));
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap        = $urandom_range(0, 6);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                    : $urandom_range(1, 10);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic random_op(int add_weight);
        int            pick;
        t_mode         mode;
        logic [IW-1:0] idx;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            mode = t_mode'($urandom_range(0, 3));
            idx  = IW'($urandom_range(0, 2**IW - 1));
        end else if (pick < 8 + add_weight) begin
            mode = ($urandom_range(0, 1) == 0) ? MODE_APPEND : MODE_INSERT;
            idx  = (mode == MODE_APPEND) ? IW'($urandom_range(0, 2**IW - 1))
                                         : IW'($urandom_range(0, shadow_count));
        end else begin
            mode = ($urandom_range(0, 9) < 6) ? MODE_GET : MODE_SET;
            if (shadow_count == 0 || $urandom_range(0, 9) == 0) idx = IW'(shadow_count);
            else idx = IW'($urandom_range(0, shadow_count - 1));
        end
        send_word(mode, idx, $urandom);
        pace_sender();
    endtask

    task automatic test_empty_array();
        stall_style = STALL_LIGHT;
        send_word(MODE_GET, 0, '0);
        send_word(MODE_SET, 0, '1);
        send_word(MODE_INSERT, 1, 32'h1111_2222);
        send_word(MODE_GET, 7'd127, '0);
        drain_results();
    endtask

    task automatic test_basic_ops();
        stall_style = STALL_NONE;
        send_word(MODE_INSERT, 0, '1);
        send_word(MODE_APPEND, 7'd127, '0);
        send_word(MODE_APPEND, 0, 32'hA5A5_5A5A);
        send_word(MODE_GET, 0, '0);
        send_word(MODE_GET, 1, '1);
        send_word(MODE_GET, 2, '0);
        send_word(MODE_GET, 3, '0);
        send_word(MODE_SET, 1, 32'h5A5A_A5A5);
        send_word(MODE_GET, 1, '0);
        send_word(MODE_INSERT, 1, 32'h1234_5678);
        send_word(MODE_INSERT, 0, '0);
        send_word(MODE_INSERT, 7, 32'hDEAD_BEEF);
        send_word(MODE_INSERT, 5, 32'h8000_0001);
        send_word(MODE_GET, 2, '0);
        send_word(MODE_GET, 5, '0);
        send_word(MODE_GET, 7'd64, '0);
        send_word(MODE_SET, 7'd64, '1);
        drain_results();
    endtask

    task automatic test_random_build();
        int n;
        n = 0;
        while (shadow_count < CAP && n < 400) begin
            if (n % 40 == 0) stall_style = $urandom_range(STALL_NONE, STALL_PATTERN);
            random_op(35);
            n++;
        end
        drain_results();
    endtask

    task automatic test_full_array();
        stall_style = STALL_LIGHT;
        while (shadow_count < CAP) send_word(MODE_APPEND, 0, $urandom);
        send_word(MODE_APPEND, 0, '1);
        send_word(MODE_INSERT, 0, '1);
        send_word(MODE_INSERT, IW'(CAP), '0);
        send_word(MODE_INSERT, IW'(CAP + 1), '0);
        send_word(MODE_INSERT, 7'd127, '1);
        send_word(MODE_GET, IW'(CAP - 1), '0);
        send_word(MODE_SET, IW'(CAP - 1), '1);
        send_word(MODE_GET, IW'(CAP - 1), '0);
        send_word(MODE_GET, 0, '0);
        send_word(MODE_GET, IW'(CAP), '0);
        send_word(MODE_SET, IW'(CAP), '0);
        drain_results();
    endtask

    task automatic test_random_full();
        for (int n = 0; n < 250; n++) begin
            if (n % 50 == 0) stall_style = $urandom_range(STALL_NONE, STALL_PATTERN);
            random_op(15);
        end
        drain_results();
    endtask

    task automatic test_output_hold();
        stall_style  = STALL_NONE;
        hold_request = LONG_HOLD;
        for (int n = 0; n < 12; n++)
            send_word((n % 3 == 2) ? MODE_SET : MODE_GET,
                      IW'($urandom_range(0, shadow_count - 1)), $urandom);
        drain_results();
    endtask

    initial begin
        for (int k = 0; k < CAP; k++) shadow_words[k] = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_array();
        test_basic_ops();
        test_random_build();
        test_full_array();
        test_random_full();
        test_output_hold();

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (failures == 0 && pending_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
